FILE: hdl/bdc_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package bdc_pkg;

	// Width of one BCD digit.
	localparam int unsigned DIGIT_W = 4;

	// ASCII codes that the converter emits.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Double-dabble converter states.
	typedef enum logic [1:0] {
		DAB_IDLE,
		DAB_RUN,
		DAB_HOLD
	} dab_state_t;

	// Character emitter states.
	typedef enum logic [1:0] {
		EM_IDLE,
		EM_SKIP,
		EM_SEND
	} em_state_t;

	// Handoff from the converter to the emitter.
	typedef struct packed {
		logic valid;
		logic negative;
	} bdc_hand_t;

endpackage

FILE: hdl/bdc_dabble.sv
// Bit-serial double-dabble converter from a binary magnitude to packed BCD.
`timescale 1ns / 1ps

module bdc_dabble #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned NDIG  = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  logic [WIDTH-1:0]                       magnitude,
	input  logic                                   negative,
	input  logic                                   take,
	output logic                                   busy,
	output bdc_pkg::bdc_hand_t                     hand,
	output logic [NDIG*bdc_pkg::DIGIT_W-1:0]       bcd
);

	localparam int unsigned BCD_W = NDIG * bdc_pkg::DIGIT_W;
	localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	bdc_pkg::dab_state_t state_q;
	bdc_pkg::dab_state_t state_d;
	logic [WIDTH-1:0]    bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [BCD_W-1:0]    bcd_adj;
	logic [CNT_W-1:0]    cnt_q;
	logic                neg_q;

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*bdc_pkg::DIGIT_W +: bdc_pkg::DIGIT_W] >= 4'd5) begin
				bcd_adj[i*bdc_pkg::DIGIT_W +: bdc_pkg::DIGIT_W] =
					bcd_q[i*bdc_pkg::DIGIT_W +: bdc_pkg::DIGIT_W] + 4'd3;
			end else begin
				bcd_adj[i*bdc_pkg::DIGIT_W +: bdc_pkg::DIGIT_W] =
					bcd_q[i*bdc_pkg::DIGIT_W +: bdc_pkg::DIGIT_W];
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdc_pkg::DAB_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: one binary bit enters the BCD register per cycle.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdc_pkg::DAB_IDLE: begin
				if (load) begin
					state_d = bdc_pkg::DAB_RUN;
				end
			end
			bdc_pkg::DAB_RUN: begin
				if (cnt_q == '0) begin
					state_d = bdc_pkg::DAB_HOLD;
				end
			end
			bdc_pkg::DAB_HOLD: begin
				if (take) begin
					state_d = bdc_pkg::DAB_IDLE;
				end
			end
			default: begin
				state_d = bdc_pkg::DAB_IDLE;
			end
		endcase
	end

	// Shift registers for the binary word, the BCD digits and the bit count.
	always_ff @(posedge clk) begin
		if (state_q == bdc_pkg::DAB_IDLE && load) begin
			bin_q <= magnitude;
			bcd_q <= '0;
			cnt_q <= CNT_W'(WIDTH - 1);
			neg_q <= negative;
		end else if (state_q == bdc_pkg::DAB_RUN) begin
			bin_q <= {bin_q[WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[WIDTH-1]};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign busy          = (state_q != bdc_pkg::DAB_IDLE);
	assign hand.valid    = (state_q == bdc_pkg::DAB_HOLD);
	assign hand.negative = neg_q;
	assign bcd           = bcd_q;

	// The emitter takes a result only when one is held.
	a_take_held: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> state_q == bdc_pkg::DAB_HOLD)
		else $error("converter result taken while none is held");

	// The last bit leads to the hold state.
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bdc_pkg::DAB_RUN && cnt_q == '0) |=> state_q == bdc_pkg::DAB_HOLD)
		else $error("conversion did not finish after the last bit");

endmodule

FILE: hdl/bdc_emit.sv
// Character emitter: skips leading zeros and sends sign and digits as ASCII.
`timescale 1ns / 1ps

module bdc_emit #(
	parameter int unsigned NDIG = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdc_pkg::bdc_hand_t                hand,
	input  logic [NDIG*bdc_pkg::DIGIT_W-1:0]  bcd,
	output logic                              take,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        digit_char,
	output logic                              last
);

	localparam int unsigned BCD_W  = NDIG * bdc_pkg::DIGIT_W;
	localparam int unsigned LEFT_W = $clog2(NDIG + 1);

	bdc_pkg::em_state_t             state_q;
	bdc_pkg::em_state_t             state_d;
	logic [BCD_W-1:0]               digs_q;
	logic [LEFT_W-1:0]              left_q;
	logic                           sign_q;
	logic [bdc_pkg::DIGIT_W-1:0]    top_dig;
	logic                           ld;
	logic                           ld_last;
	logic                           out_valid_q;
	logic [7:0]                     char_q;
	logic                           last_q;

	assign top_dig = digs_q[BCD_W-1 -: bdc_pkg::DIGIT_W];
	assign take    = (state_q == bdc_pkg::EM_IDLE) && hand.valid;
	assign ld      = (state_q == bdc_pkg::EM_SEND) && (!out_valid_q || !out_stall);
	assign ld_last = ld && !sign_q && (left_q == LEFT_W'(1));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdc_pkg::EM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: drop leading zeros, then send one character per free slot.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bdc_pkg::EM_IDLE: begin
				if (hand.valid) begin
					state_d = bdc_pkg::EM_SKIP;
				end
			end
			bdc_pkg::EM_SKIP: begin
				if (top_dig != '0 || left_q == LEFT_W'(1)) begin
					state_d = bdc_pkg::EM_SEND;
				end
			end
			bdc_pkg::EM_SEND: begin
				if (ld_last) begin
					state_d = bdc_pkg::EM_IDLE;
				end
			end
			default: begin
				state_d = bdc_pkg::EM_IDLE;
			end
		endcase
	end

	// Digit shift register, remaining digit count and pending sign.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= 1'b0;
			left_q <= '0;
		end else if (take) begin
			sign_q <= hand.negative;
			left_q <= LEFT_W'(NDIG);
		end else if (state_q == bdc_pkg::EM_SKIP && state_d == bdc_pkg::EM_SKIP) begin
			left_q <= left_q - 1'b1;
		end else if (ld && sign_q) begin
			sign_q <= 1'b0;
		end else if (ld) begin
			left_q <= left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			digs_q <= bcd;
		end else if ((state_q == bdc_pkg::EM_SKIP && state_d == bdc_pkg::EM_SKIP) ||
				(ld && !sign_q)) begin
			digs_q <= {digs_q[BCD_W-bdc_pkg::DIGIT_W-1:0], {bdc_pkg::DIGIT_W{1'b0}}};
		end
	end

	// Output register parts the emitter from the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			if (sign_q) begin
				char_q <= bdc_pkg::CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= bdc_pkg::CHAR_ZERO + {4'b0000, top_dig};
				last_q <= (left_q == LEFT_W'(1));
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last       = last_q;

	// Sending the final character ends the number.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ld_last |=> state_q == bdc_pkg::EM_IDLE)
		else $error("emitter still busy after the final character");

	// A number in progress always has at least one digit left.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bdc_pkg::EM_IDLE) |-> left_q != '0)
		else $error("emitter ran out of digits");

	// The sign is only sent as the first character, never as the last.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && sign_q) |=> !last_q)
		else $error("minus sign marked as last character");

endmodule

FILE: hdl/binary_to_decimal_ascii_unit.sv
// Top level of the binary to decimal ASCII converter.
//
// Input channel: in_valid / in_stall carry one item, a word (value) and a
// signedness select (func: 0 unsigned, 1 two's complement). Output channel:
// out_valid / out_stall carry one ASCII character per item on digit_char,
// most significant first, with a leading '-' for negative signed words; last
// marks the final character. Zero prints as a single '0'.
// An accepted word is negated if needed, then converted by a bit-serial
// double-dabble unit, one bit per cycle. The emitter then drops leading
// zeros at one digit per cycle and, while the output is not stalled, sends
// one character per cycle into an output register. The converter takes the
// next word as soon as the emitter has taken its result, so it converts a
// new word while the emitter still sends the characters of the last one.
// A stalled output holds its character; the emitter and then the converter
// back up, and in_stall stays high until the converter is free.
// Reset clears all control state; no item is in flight after reset.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   func,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             digit_char,
	output logic                   last
);

	// Decimal digits needed for the largest word: floor(W * log10(2)) + 1.
	localparam int unsigned NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int unsigned BCD_W = NDIG * bdc_pkg::DIGIT_W;

	logic                   accept;
	logic                   negative;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic                   busy;
	logic                   take;
	bdc_pkg::bdc_hand_t     hand;
	logic [BCD_W-1:0]       bcd;

	assign in_stall = busy;
	assign accept   = in_valid && !in_stall;

	// Two's complement magnitude of a negative signed word.
	assign negative  = func && value[VALUE_WIDTH-1];
	assign magnitude = negative ? (~value + VALUE_WIDTH'(1)) : value;

	bdc_dabble #(
		.WIDTH (VALUE_WIDTH),
		.NDIG  (NDIG)
	) u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.magnitude (magnitude),
		.negative  (negative),
		.take      (take),
		.busy      (busy),
		.hand      (hand),
		.bcd       (bcd)
	);

	bdc_emit #(
		.NDIG (NDIG)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.hand       (hand),
		.bcd        (bcd),
		.take       (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

	// An accepted item keeps the converter busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("converter not busy after an item was accepted");

endmodule

FILE: test/bdc_checker.sv
// Checker that predicts the decimal text of each accepted word and compares every character.
`timescale 1ns / 1ps

module bdc_checker #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic                   func,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [7:0]             digit_char,
	input  logic                   last,
	output int unsigned            fail_count,
	output int unsigned            chars_owed
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_char_t;

	// Characters still to come, oldest first.
	text_char_t  text_due[$];
	int unsigned n_fail = 0;

	// Appends the decimal text of one word, sign first, digits most significant first.
	function automatic void add_decimal_text(input logic is_signed,
			input logic [VALUE_WIDTH-1:0] word);
		logic [VALUE_WIDTH-1:0] mag;
		logic [7:0]             rev[$];
		logic                   negative;
		text_char_t             c;
		negative = is_signed && word[VALUE_WIDTH-1];
		// The magnitude is taken as unsigned, so the most negative word prints correctly.
		mag = negative ? (~word + 1'b1) : word;
		do begin
			rev.push_back(bdc_pkg::CHAR_ZERO + 8'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (negative) begin
			c.ch   = bdc_pkg::CHAR_MINUS;
			c.last = 1'b0;
			text_due.push_back(c);
		end
		while (rev.size() != 0) begin
			c.ch   = rev.pop_back();
			c.last = (rev.size() == 0);
			text_due.push_back(c);
		end
	endfunction

	// Predict on every accepted word and check every accepted character.
	always @(posedge clk or negedge arst_n) begin : watch
		text_char_t want;
		if (!arst_n) begin
			text_due.delete();
		end else begin
			if (in_valid && !in_stall) begin
				add_decimal_text(func, value);
			end
			if (out_valid && !out_stall) begin
				if (text_due.size() == 0) begin
					n_fail++;
					$error("digit_char: expected nothing, got %h (last %b)", digit_char, last);
				end else begin
					want = text_due.pop_front();
					if (digit_char !== want.ch) begin
						n_fail++;
						$error("digit_char: expected %h, got %h", want.ch, digit_char);
					end
					if (last !== want.last) begin
						n_fail++;
						$error("last: expected %b, got %b", want.last, last);
					end
				end
			end
		end
		fail_count <= n_fail;
		chars_owed <= text_due.size();
	end

endmodule

FILE: test/tb_top.sv
// Top of the converter testbench: clock, reset, word stimulus, character sink and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned VALUE_WIDTH  = 32;
	localparam int unsigned RANDOM_WORDS = 360;
	localparam int unsigned N_DIRECTED   = 20;
	// The sink stops taking characters for a long stretch once this many have passed.
	localparam int unsigned CHOKE_AT     = 400;
	localparam int unsigned CHOKE_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 80;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   func;
	logic [VALUE_WIDTH-1:0] value;
	logic                   out_valid;
	logic                   out_stall;
	logic [7:0]             digit_char;
	logic                   last;
	int unsigned            fail_count;
	int unsigned            chars_owed;

	// Directed words as {func, value}.
	logic [VALUE_WIDTH:0] directed [N_DIRECTED] = '{
		{1'b0, 32'd0},          {1'b1, 32'd0},
		{1'b0, 32'd1},          {1'b1, 32'd1},
		{1'b0, 32'd9},          {1'b0, 32'd10},
		{1'b1, 32'hFFFF_FFFF},  {1'b0, 32'hFFFF_FFFF},
		{1'b1, 32'h8000_0000},  {1'b0, 32'h8000_0000},
		{1'b1, 32'h7FFF_FFFF},  {1'b0, 32'h7FFF_FFFF},
		{1'b0, 32'd999999999},  {1'b0, 32'd1000000000},
		{1'b1, 32'hC465_3600},  {1'b1, 32'hFFFF_FFF6},
		{1'b1, 32'hFFFF_FFF7},  {1'b0, 32'd100},
		{1'b1, 32'h8000_0001},  {1'b0, 32'd4000000000}
	};

	binary_to_decimal_ascii_unit #(.VALUE_WIDTH(VALUE_WIDTH)) dut (.*);

	bdc_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Reset, asserted once at the start.
	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Overall time limit.
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Idle cycles before the next item; each run of items is drawn quiet (no gaps) or busy.
	function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit quiet);
		if (run_left == 0) begin
			run_left = $urandom_range(10, 40);
			quiet    = ($urandom_range(0, 2) == 0);
		end
		run_left--;
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	int unsigned send_run   = 0;
	bit          send_quiet = 1'b0;

	// Offers one word and returns at the edge where it is taken.
	task automatic send_word(input logic f, input logic [VALUE_WIDTH-1:0] v);
		int unsigned gap;
		gap = draw_gap(send_run, send_quiet);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Character sink: random stalls, quiet stretches and one long hold-off.
	initial begin : sink
		int unsigned run_left;
		int unsigned hold;
		int unsigned chars_seen;
		bit          quiet;
		run_left   = 0;
		quiet      = 1'b0;
		chars_seen = 0;
		out_stall <= 1'b0;
		wait (arst_n);
		forever begin
			hold = draw_gap(run_left, quiet);
			if (chars_seen == CHOKE_AT) begin
				hold = CHOKE_CYCLES;
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			chars_seen++;
		end
	end

	// Word source, then drain and verdict.
	initial begin : source
		logic                   f;
		logic [VALUE_WIDTH-1:0] v;
		int unsigned            lim;
		in_valid <= 1'b0;
		func     <= 1'b0;
		value    <= '0;
		wait (arst_n);
		@(posedge clk);

		// Extremes, zero in both modes, sign and digit-count boundaries.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_word(directed[i][VALUE_WIDTH], directed[i][VALUE_WIDTH-1:0]);
		end

		// Random words of every length, with the edges of both ranges mixed in.
		repeat (RANDOM_WORDS) begin
			f = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0: begin
					v = $urandom();
				end
				1: begin
					v = $urandom_range(0, 99);
					if (f && $urandom_range(0, 1)) v = -v;
				end
				2: begin
					lim = 1;
					repeat ($urandom_range(1, 9)) lim = lim * 10;
					v = $urandom_range(0, lim - 1);
					if (f && $urandom_range(0, 1)) v = -v;
				end
				default: begin
					case ($urandom_range(0, 3))
						0: v = 32'h0000_0000;
						1: v = 32'h8000_0000;
						2: v = 32'h7FFF_FFFF;
						default: v = 32'hFFFF_FFFF;
					endcase
					if ($urandom_range(0, 1)) v = v + $urandom_range(0, 20);
					else v = v - $urandom_range(0, 20);
				end
			endcase
			send_word(f, v);
		end
		in_valid <= 1'b0;

		// Wait for every predicted character, then a little longer for strays.
		@(posedge clk);
		while (chars_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/bdc_pkg.sv
hdl/bdc_dabble.sv
hdl/bdc_emit.sv
hdl/binary_to_decimal_ascii_unit.sv
test/bdc_checker.sv
test/tb_top.sv
